// ===== hdl/bpa_pkg.sv =====
// Shared constants, types and helper functions of the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int unsigned MaxOrder    = 10;
  localparam int unsigned PageW       = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned OrdW        = 4;
  localparam int unsigned NodeW       = 11;
  localparam int unsigned BitW        = 5;
  localparam int unsigned RowBits     = 1 << BitW;
  localparam int unsigned RowW        = NodeW - BitW;
  localparam int unsigned MapRows     = 1 << RowW;
  localparam int unsigned RegionPages = 1 << MaxOrder;
  localparam int unsigned FreeCap     = (2 << MaxOrder) - 1;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2
  } action_e;

  typedef enum logic [4:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_INIT_CLR,
    ST_INIT_NEXT,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_AL_RD,
    ST_AL_CHK,
    ST_AL_SPLIT,
    ST_FR_RD,
    ST_FR_ORD,
    ST_FR_CRD,
    ST_FR_CCHK,
    ST_FR_MRD,
    ST_FR_MCHK,
    ST_FR_FIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [RowW-1:0]      waddr;
    logic [RowBits-1:0]   wdata;
    logic [RowW-1:0]      raddr;
  } map_req_t;

  typedef struct packed {
    logic                 we;
    logic [PageW-1:0]     waddr;
    logic [OrdW-1:0]      wdata;
    logic [PageW-1:0]     raddr;
  } ord_req_t;

  // First node of an order in the free-bit tree.
  function automatic logic [NodeW-1:0] node_base(logic [OrdW-1:0] o);
    node_base = (NodeW'(1) << (OrdW'(MaxOrder) - o)) - NodeW'(1);
  endfunction

  // Last node of an order; it is always twice the first one.
  function automatic logic [NodeW-1:0] node_last(logic [OrdW-1:0] o);
    node_last = node_base(o) << 1;
  endfunction

  function automatic logic [NodeW-1:0] node_of(logic [OrdW-1:0] o, logic [PageW-1:0] start);
    node_of = node_base(o) + NodeW'(start >> o);
  endfunction

endpackage

// ===== hdl/bpa_if.sv =====
// Handshake interfaces of the request and response channels.
`timescale 1ns / 1ps
interface bpa_req_if;
  import bpa_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [CntW-1:0]  page_count;
  logic [PageW-1:0] page_index;
  modport source(output valid, action, page_count, page_index, input ready);
  modport sink(input valid, action, page_count, page_index, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic             valid;
  logic             ready;
  logic             ok;
  logic [PageW-1:0] block_start;
  logic [OrdW-1:0]  block_order;
  logic [CntW-1:0]  avail_pages;
  modport source(output valid, ok, block_start, block_order, avail_pages, input ready);
  modport sink(input valid, ok, block_start, block_order, avail_pages, output ready);
endinterface

// ===== hdl/bpa_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bpa_ctrl.sv =====
// Sequencer that walks the free-bit tree and the order table for each request.
`timescale 1ns / 1ps
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  bpa_req_if.sink            req_i,
  bpa_rsp_if.source          rsp_o,
  output map_req_t           map_req_o,
  input  logic [RowBits-1:0] map_rdata_i,
  output ord_req_t           ord_req_o,
  input  logic [OrdW-1:0]    ord_rdata_i
);

  state_e           state_q, state_d, ret_q, ret_d;
  logic [PageW-1:0] cnt_q, cnt_d;
  logic [OrdW-1:0]  cur_o_q, cur_o_d, need_q, need_d;
  logic [PageW-1:0] start_q, start_d, page_q, page_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [NodeW-1:0] node_q, node_d;
  logic             set_q, set_d;
  logic [CntW-1:0]  count_q, count_d, total_q, total_d;
  logic             res_ok_q, res_ok_d;
  logic [PageW-1:0] res_start_q, res_start_d;
  logic [OrdW-1:0]  res_order_q, res_order_d;
  logic             out_valid_q;
  logic             out_ok_q;
  logic [PageW-1:0] out_start_q;
  logic [OrdW-1:0]  out_order_q;
  logic [CntW-1:0]  out_free_q;

  logic [CntW-1:0]    req_cnt_c;
  logic [OrdW-1:0]    need_c, top_c;
  logic               alloc_big_c;
  logic [NodeW-1:0]   lo_c, hi_c, base_need_c, base_next_c, hit_node_c;
  logic [RowBits-1:0] hit_mask_c;
  logic [BitW-1:0]    hit_bit_c;
  logic               hit_c;
  logic [OrdW-1:0]    dn_o_c;
  logic [PageW-1:0]   split_start_c;
  logic [NodeW-1:0]   chk_node_c, bud_node_c;
  logic [CntW-1:0]    align_mask_c;
  logic [CntW:0]      sum_c;
  logic [CntW-1:0]    need_pages_c;
  logic [RowBits-1:0] rmw_row_c;
  logic               out_load_c;

  // Request decode: rounded-up order of an allocation.
  always_comb begin
    req_cnt_c = (req_i.page_count == '0) ? CntW'(1) : req_i.page_count;
    alloc_big_c = req_cnt_c > CntW'(RegionPages);
    need_c = OrdW'(MaxOrder);
    for (int n = MaxOrder; n >= 0; n--) begin
      if ((CntW'(1) << n) >= req_cnt_c) begin
        need_c = OrdW'(n);
      end
    end
    base_need_c = node_base(need_c);
  end

  // Highest set bit of the remaining init count.
  always_comb begin
    top_c = '0;
    for (int i = 0; i < CntW; i++) begin
      if (count_q[i]) begin
        top_c = OrdW'(i);
      end
    end
  end

  // Search of one free-map row for the lowest free node of the current order.
  always_comb begin
    lo_c = node_base(cur_o_q);
    hi_c = node_last(cur_o_q);
    base_next_c = node_base(cur_o_q + OrdW'(1));
    for (int i = 0; i < RowBits; i++) begin
      hit_mask_c[i] = map_rdata_i[i] && ({row_q, BitW'(i)} >= lo_c) &&
                      ({row_q, BitW'(i)} <= hi_c);
    end
    hit_bit_c = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (hit_mask_c[i]) begin
        hit_bit_c = BitW'(i);
      end
    end
    hit_c = |hit_mask_c;
    hit_node_c = {row_q, hit_bit_c};
  end

  always_comb begin
    dn_o_c = cur_o_q - OrdW'(1);
    split_start_c = start_q + (PageW'(1) << dn_o_c);
    chk_node_c = node_of(cur_o_q, page_q);
    bud_node_c = node_of(cur_o_q, start_q ^ (PageW'(1) << cur_o_q));
    align_mask_c = (CntW'(1) << ord_rdata_i) - CntW'(1);
    need_pages_c = CntW'(1) << need_q;
    sum_c = {1'b0, total_q} + {1'b0, need_pages_c};
    rmw_row_c = map_rdata_i;
    rmw_row_c[node_q[BitW-1:0]] = set_q;
    out_load_c = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);
  end

  // Next state and working registers.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    cur_o_d     = cur_o_q;
    need_d      = need_q;
    start_d     = start_q;
    page_d      = page_q;
    row_d       = row_q;
    node_d      = node_q;
    set_d       = set_q;
    count_d     = count_q;
    total_d     = total_q;
    res_ok_d    = res_ok_q;
    res_start_d = res_start_q;
    res_order_d = res_order_q;
    case (state_q)
      ST_RST_CLR: begin
        cnt_d = cnt_q + PageW'(1);
        if (cnt_q[RowW-1:0] == {RowW{1'b1}}) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        res_ok_d    = 1'b0;
        res_start_d = '0;
        res_order_d = '0;
        if (req_i.valid) begin
          state_d = ST_FIN;
          case (req_i.action)
            ACT_INIT: begin
              cnt_d   = '0;
              start_d = '0;
              count_d = (req_i.page_count > CntW'(RegionPages)) ? CntW'(RegionPages)
                                                              : req_i.page_count;
              state_d = ST_INIT_CLR;
            end
            ACT_ALLOC: begin
              if (!alloc_big_c) begin
                cur_o_d = need_c;
                need_d  = need_c;
                row_d   = base_need_c[NodeW-1:BitW];
                state_d = ST_AL_RD;
              end
            end
            ACT_FREE: begin
              page_d  = req_i.page_index;
              state_d = ST_FR_RD;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_INIT_CLR: begin
        cnt_d = cnt_q + PageW'(1);
        if (cnt_q == {PageW{1'b1}}) begin
          total_d = count_q;
          state_d = ST_INIT_NEXT;
        end
      end
      ST_INIT_NEXT: begin
        if (count_q == '0) begin
          res_ok_d = 1'b1;
          state_d  = ST_FIN;
        end else begin
          node_d  = node_of(top_c, start_q);
          set_d   = 1'b1;
          start_d = start_q + PageW'(CntW'(1) << top_c);
          count_d = count_q & ~(CntW'(1) << top_c);
          ret_d   = ST_INIT_NEXT;
          state_d = ST_RMW_RD;
        end
      end
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: state_d = ret_q;
      ST_AL_RD:  state_d = ST_AL_CHK;
      ST_AL_CHK: begin
        if (hit_c) begin
          start_d = PageW'((hit_node_c - lo_c) << cur_o_q);
          state_d = ST_AL_SPLIT;
        end else if (row_q == hi_c[NodeW-1:BitW]) begin
          if (cur_o_q == OrdW'(MaxOrder)) begin
            state_d = ST_FIN;
          end else begin
            cur_o_d = cur_o_q + OrdW'(1);
            row_d   = base_next_c[NodeW-1:BitW];
            state_d = ST_AL_RD;
          end
        end else begin
          row_d   = row_q + RowW'(1);
          state_d = ST_AL_RD;
        end
      end
      ST_AL_SPLIT: begin
        if (cur_o_q > need_q) begin
          // Free the high half and keep splitting the low half.
          cur_o_d = dn_o_c;
          node_d  = node_of(dn_o_c, split_start_c);
          set_d   = 1'b1;
          ret_d   = ST_AL_SPLIT;
          state_d = ST_RMW_RD;
        end else begin
          total_d     = (total_q >= need_pages_c) ? total_q - need_pages_c : '0;
          res_ok_d    = 1'b1;
          res_start_d = start_q;
          res_order_d = need_q;
          state_d     = ST_FIN;
        end
      end
      ST_FR_RD: state_d = ST_FR_ORD;
      ST_FR_ORD: begin
        if ((ord_rdata_i > OrdW'(MaxOrder)) ||
            ((CntW'(page_q) & align_mask_c) != '0)) begin
          state_d = ST_FIN;
        end else begin
          cur_o_d = ord_rdata_i;
          need_d  = ord_rdata_i;
          state_d = ST_FR_CRD;
        end
      end
      ST_FR_CRD: state_d = ST_FR_CCHK;
      ST_FR_CCHK: begin
        // A free block at this order or above means a double free.
        if (map_rdata_i[chk_node_c[BitW-1:0]]) begin
          state_d = ST_FIN;
        end else if (cur_o_q == OrdW'(MaxOrder)) begin
          total_d = (sum_c > (CntW + 1)'(FreeCap)) ? CntW'(FreeCap) : sum_c[CntW-1:0];
          start_d = page_q;
          cur_o_d = need_q;
          state_d = ST_FR_MRD;
        end else begin
          cur_o_d = cur_o_q + OrdW'(1);
          state_d = ST_FR_CRD;
        end
      end
      ST_FR_MRD: begin
        if (cur_o_q == OrdW'(MaxOrder)) begin
          node_d  = node_of(cur_o_q, start_q);
          set_d   = 1'b1;
          ret_d   = ST_FR_FIN;
          state_d = ST_RMW_RD;
        end else begin
          state_d = ST_FR_MCHK;
        end
      end
      ST_FR_MCHK: begin
        if (map_rdata_i[bud_node_c[BitW-1:0]]) begin
          start_d = start_q & ~(PageW'(1) << cur_o_q);
          cur_o_d = cur_o_q + OrdW'(1);
          state_d = ST_FR_MRD;
        end else begin
          node_d  = node_of(cur_o_q, start_q);
          set_d   = 1'b1;
          ret_d   = ST_FR_FIN;
          state_d = ST_RMW_RD;
        end
      end
      ST_FR_FIN: begin
        res_ok_d    = 1'b1;
        res_start_d = start_q;
        res_order_d = cur_o_q;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (out_load_c) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory requests and handshake outputs.
  always_comb begin
    map_req_o   = '0;
    ord_req_o   = '0;
    req_i.ready = (state_q == ST_IDLE);
    case (state_q)
      ST_RST_CLR: begin
        map_req_o.we    = 1'b1;
        map_req_o.waddr = cnt_q[RowW-1:0];
      end
      ST_INIT_CLR: begin
        ord_req_o.we    = 1'b1;
        ord_req_o.waddr = cnt_q;
        map_req_o.we    = (cnt_q[PageW-1:RowW] == '0);
        map_req_o.waddr = cnt_q[RowW-1:0];
      end
      ST_RMW_RD: map_req_o.raddr = node_q[NodeW-1:BitW];
      ST_RMW_WR: begin
        map_req_o.we    = 1'b1;
        map_req_o.waddr = node_q[NodeW-1:BitW];
        map_req_o.wdata = rmw_row_c;
      end
      ST_AL_RD: map_req_o.raddr = row_q;
      ST_AL_CHK: begin
        map_req_o.we    = hit_c;
        map_req_o.waddr = row_q;
        map_req_o.wdata = map_rdata_i & ~(RowBits'(1) << hit_bit_c);
      end
      ST_AL_SPLIT: begin
        ord_req_o.we    = !(cur_o_q > need_q);
        ord_req_o.waddr = start_q;
        ord_req_o.wdata = need_q;
      end
      ST_FR_RD:  ord_req_o.raddr = page_q;
      ST_FR_CRD: map_req_o.raddr = chk_node_c[NodeW-1:BitW];
      ST_FR_MRD: map_req_o.raddr = bud_node_c[NodeW-1:BitW];
      ST_FR_MCHK: begin
        map_req_o.we    = map_rdata_i[bud_node_c[BitW-1:0]];
        map_req_o.waddr = bud_node_c[NodeW-1:BitW];
        map_req_o.wdata = map_rdata_i & ~(RowBits'(1) << bud_node_c[BitW-1:0]);
      end
      default: map_req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RST_CLR;
      ret_q       <= ST_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      if (out_load_c) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_o_q     <= cur_o_d;
    need_q      <= need_d;
    start_q     <= start_d;
    page_q      <= page_d;
    row_q       <= row_d;
    node_q      <= node_d;
    set_q       <= set_d;
    count_q     <= count_d;
    res_ok_q    <= res_ok_d;
    res_start_q <= res_start_d;
    res_order_q <= res_order_d;
    if (out_load_c) begin
      out_ok_q    <= res_ok_q;
      out_start_q <= res_start_q;
      out_order_q <= res_order_q;
      out_free_q  <= total_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ok          = out_ok_q;
  assign rsp_o.block_start = out_start_q;
  assign rsp_o.block_order = out_order_q;
  assign rsp_o.avail_pages = out_free_q;

endmodule

// ===== hdl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: sequencer and its two memories.
//
//   channel  dir  transaction                                  payload
//   req_i    in   one request (init, allocate or free)         action, page_count, page_index
//   rsp_o    out  one response per request                     ok, block_start, block_order,
//                                                              avail_pages
//
// After reset the free-bit memory is cleared, all 64 rows of it, before req_i.ready rises.
// Init clears both memories, then carves the page count into aligned blocks.
// Allocate scans free-bit rows (up to 74 rows), then splits the found block down to its order.
// Free looks up the order, checks each order for a double free, merges with free buddies and
// then sets the merged block; every request also passes through the idle and finishing states.
// The response sits in an output register; a new request is taken while it waits.
`timescale 1ns / 1ps
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);

  map_req_t           map_req;
  ord_req_t           ord_req;
  logic [RowBits-1:0] map_rdata;
  logic [OrdW-1:0]    ord_rdata;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .map_req_o   (map_req),
    .map_rdata_i (map_rdata),
    .ord_req_o   (ord_req),
    .ord_rdata_i (ord_rdata)
  );

  // Free bits of every aligned block, 32 tree nodes per row.
  bpa_ram #(
    .Width (RowBits),
    .Depth (MapRows)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_req.we),
    .waddr_i (map_req.waddr),
    .wdata_i (map_req.wdata),
    .raddr_i (map_req.raddr),
    .rdata_o (map_rdata)
  );

  // Order of each allocated block, indexed by its start page.
  bpa_ram #(
    .Width (OrdW),
    .Depth (RegionPages)
  ) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_req.we),
    .waddr_i (ord_req.waddr),
    .wdata_i (ord_req.wdata),
    .raddr_i (ord_req.raddr),
    .rdata_o (ord_rdata)
  );

endmodule

// ===== sim/buddy_page_allocator_checker.sv =====
// Response checker of the buddy page allocator: predicts each response and compares it.
`timescale 1ns / 1ps
module buddy_page_allocator_checker
  import bpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bpa_req_if.sink   req_mon,
  bpa_rsp_if.sink   rsp_mon,
  output int        fail_count,
  output int        pending_count
);

  typedef struct packed {
    logic             ok;
    logic [PageW-1:0] start;
    logic [OrdW-1:0]  order;
    logic [CntW-1:0]  avail_pages;
  } alloc_rsp_t;

  localparam int unsigned NodeCount = (2 << MaxOrder) - 1;

  logic       tree_free [NodeCount];
  logic [3:0] page_order [RegionPages];
  int         free_tally;
  alloc_rsp_t expected_rsps[$];

  function automatic int node_idx(int o, int start);
    return ((1 << (MaxOrder - o)) - 1) + (start >> o);
  endfunction

  function automatic void clear_maps();
    foreach (tree_free[i]) tree_free[i] = 1'b0;
    foreach (page_order[i]) page_order[i] = '0;
  endfunction

  // Applies one request to the private copy of the allocator state.
  function automatic alloc_rsp_t predict_rsp(logic [1:0] act, int cnt, int page);
    alloc_rsp_t r;
    int o, need, start, ord, buddy;
    bit found, busy;
    r = '0;
    if (act == ACT_INIT) begin
      clear_maps();
      if (cnt > RegionPages) cnt = RegionPages;
      free_tally = cnt;
      start = 0;
      while (cnt != 0) begin
        o = 0;
        while (o < MaxOrder && (2 << o) <= cnt) o++;
        tree_free[node_idx(o, start)] = 1'b1;
        start += 1 << o;
        cnt -= 1 << o;
      end
      r.ok = 1'b1;
    end else if (act == ACT_ALLOC) begin
      if (cnt == 0) cnt = 1;
      need = 0;
      while (need <= MaxOrder && (1 << need) < cnt) need++;
      found = 1'b0;
      if (need <= MaxOrder) begin
        for (o = need; o <= MaxOrder && !found; o++) begin
          for (int b = 0; b < (1 << (MaxOrder - o)) && !found; b++) begin
            if (tree_free[node_idx(o, b << o)]) begin
              found = 1'b1;
              start = b << o;
              tree_free[node_idx(o, start)] = 1'b0;
              for (int k = o - 1; k >= need; k--)
                tree_free[node_idx(k, start + (1 << k))] = 1'b1;
              page_order[start] = OrdW'(need);
              free_tally = (free_tally >= (1 << need)) ? free_tally - (1 << need) : 0;
              r.ok = 1'b1;
              r.start = PageW'(start);
              r.order = OrdW'(need);
            end
          end
        end
      end
    end else if (act == ACT_FREE) begin
      ord = page_order[page];
      busy = (ord > MaxOrder) || ((page & ((1 << ord) - 1)) != 0);
      if (!busy)
        for (o = ord; o <= MaxOrder; o++)
          if (tree_free[node_idx(o, page & ~((1 << o) - 1))]) busy = 1'b1;
      if (!busy) begin
        free_tally += 1 << ord;
        if (free_tally > FreeCap) free_tally = FreeCap;
        start = page;
        o = ord;
        while (o < MaxOrder) begin
          buddy = start ^ (1 << o);
          if (!tree_free[node_idx(o, buddy)]) break;
          tree_free[node_idx(o, buddy)] = 1'b0;
          start &= ~(1 << o);
          o++;
        end
        tree_free[node_idx(o, start)] = 1'b1;
        r.ok = 1'b1;
        r.start = PageW'(start);
        r.order = OrdW'(o);
      end
    end
    r.avail_pages = CntW'(free_tally);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    free_tally    = 0;
    clear_maps();
  end

  always @(posedge clk_i) begin
    alloc_rsp_t want;
    if (rst_ni && req_mon.valid && req_mon.ready)
      expected_rsps.push_back(predict_rsp(req_mon.action, int'(req_mon.page_count),
                                          int'(req_mon.page_index)));
    if (rst_ni && rsp_mon.valid && rsp_mon.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: response transaction with nothing expected", $realtime);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_mon.ok !== want.ok) report_mismatch("ok", rsp_mon.ok, want.ok);
        if (rsp_mon.block_start !== want.start)
          report_mismatch("block_start", rsp_mon.block_start, want.start);
        if (rsp_mon.block_order !== want.order)
          report_mismatch("block_order", rsp_mon.block_order, want.order);
        if (rsp_mon.avail_pages !== want.avail_pages)
          report_mismatch("avail_pages", rsp_mon.avail_pages, want.avail_pages);
      end
    end
    pending_count = expected_rsps.size();
  end

endmodule

// ===== sim/buddy_page_allocator_tb.sv =====
// Testbench top of the buddy page allocator: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   live_blocks[$];

  bpa_req_if req_if();
  bpa_rsp_if rsp_if();

  buddy_page_allocator dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .rsp_o(rsp_if));

  buddy_page_allocator_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req_if), .rsp_mon(rsp_if),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // The receiver stalls at random, decided at each falling edge.
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Issues one request transaction and holds it until it is taken.
  // Valid drops only while the sender idles, so back-to-back requests keep it high.
  task automatic send_request(logic [1:0] act, int cnt, int page);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.page_count <= CntW'(cnt);
    req_if.page_index <= PageW'(page);
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Allocations are tracked loosely so that most frees name a real block.
  task automatic random_request();
    int pick, cnt, idx;
    pick = $urandom_range(99);
    if (pick < 2) begin
      send_request(ACT_INIT, ($urandom_range(3) == 0) ? $urandom_range(2047)
                                                     : $urandom_range(1024), 0);
      live_blocks.delete();
    end else if (pick < 50) begin
      case ($urandom_range(9))
        0:       cnt = $urandom_range(2047);
        1:       cnt = $urandom_range(1024);
        2, 3:    cnt = $urandom_range(64);
        default: cnt = $urandom_range(8);
      endcase
      send_request(ACT_ALLOC, cnt, $urandom_range(1023));
      live_blocks.push_back(0);
    end else if (pick < 88 && live_blocks.size() > 0) begin
      idx = $urandom_range(live_blocks.size() - 1);
      send_request(ACT_FREE, $urandom_range(2047), live_blocks[idx]);
      live_blocks.delete(idx);
    end else if (pick < 96) begin
      send_request(ACT_FREE, $urandom_range(2047), $urandom_range(1023));
    end else begin
      send_request(ActUnused, $urandom_range(2047), $urandom_range(1023));
    end
  endtask

  // Records the start of each granted block above order 0 so later frees can target it.
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready && rsp_if.ok && rsp_if.block_order != 0
        && live_blocks.size() > 0 && live_blocks[live_blocks.size()-1] == 0)
      live_blocks[live_blocks.size()-1] = int'(rsp_if.block_start);
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int waited;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_INIT;
    req_if.page_count = '0;
    req_if.page_index = '0;
    rsp_if.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_ni            = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty and oversized init, refusals, splits, merges, double free.
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_INIT, 0, 0);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_INIT, 2047, 0);
    send_request(ACT_ALLOC, 1025, 0);
    send_request(ACT_ALLOC, 1024, 0);
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_INIT, 1000, 0);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_ALLOC, 3, 0);
    send_request(ACT_ALLOC, 512, 0);
    send_request(ACT_ALLOC, 512, 0);
    send_request(ACT_FREE, 0, 6);
    send_request(ACT_FREE, 0, 4);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_FREE, 0, 1023);
    send_request(ACT_FREE, 0, 512);
    send_request(ActUnused, 2047, 1023);
    send_request(ACT_INIT, 1023, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int n = 0; n < 310; n++) random_request();
    end
    req_if.valid <= 1'b0;

    waited = 0;
    while (pending_count != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bpa_pkg.sv
hdl/bpa_if.sv
hdl/bpa_ram.sv
hdl/bpa_ctrl.sv
hdl/buddy_page_allocator.sv
sim/buddy_page_allocator_checker.sv
sim/buddy_page_allocator_tb.sv
